// ===== sv/assert_macros.svh =====
// Assertion helpers for the top-level RTL file.
// Both clock on aclk; CHK_PROP is disabled while the synchronous aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, masked while in reset.
`define CHK_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked property, also sampled during reset.
`define CHK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== sv/csrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// csrgb_pkg
// Types, codes and constants for the colour sensor gate counter.
// ----------------------------------------------------------------------------
package csrgb_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int FULL_SCALE_DEF  = 255;

    localparam int WIN_W   = 16;
    localparam int ACT_W   = 2;
    localparam int SEL_W   = 2;
    localparam int CHAN_W  = 2;
    localparam int VALUE_W = 8;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 16;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd10000;

    // one extra step on top of the value bits catches an over-range quotient
    localparam int              DIV_STEPS = VALUE_W + 1;
    localparam int              DCNT_W    = $clog2(DIV_STEPS);
    localparam logic [CHAN_W-1:0] CHAN_LAST = 2'd2;

    localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CAL  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MEAS = 2'd2;

    localparam logic [SEL_W-1:0] SEL_RED   = 2'd0;
    localparam logic [SEL_W-1:0] SEL_BLUE  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_CLEAR = 2'd2;
    localparam logic [SEL_W-1:0] SEL_GREEN = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_CAL  = 2'd1,
        MODE_MEAS = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_MUL   = 2'd1,
        ST_DIV   = 2'd2,
        ST_FIN   = 2'd3
    } state_t;

    typedef struct packed {
        logic step_en;
        logic step_out;
        logic prod_load;
        logic div_step;
        logic res_from_div;
    } cmd_t;

    typedef struct packed {
        logic out_hold;
        logic meas_close;
        logic div_last;
    } stat_t;

    function automatic logic [SEL_W-1:0] sel_of(mode_t m, logic [CHAN_W-1:0] c);
        logic [SEL_W-1:0] s;
        if (m == MODE_IDLE) begin
            s = SEL_CLEAR;
        end else begin
            case (c)
                2'd0:    s = SEL_RED;
                2'd1:    s = SEL_GREEN;
                2'd2:    s = SEL_BLUE;
                default: s = SEL_CLEAR;
            endcase
        end
        return s;
    endfunction

endpackage

// ===== sv/csrgb_ctrl.sv =====
// ----------------------------------------------------------------------------
// csrgb_ctrl
// Sequencer: takes tick requests and runs the scaling divide after a
// measurement window closes.
// ----------------------------------------------------------------------------
module csrgb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  csrgb_pkg::stat_t  stat,
    output csrgb_pkg::cmd_t   cmd
);
    import csrgb_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_READY;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_READY: begin
                s_tready = !stat.out_hold;
                if (s_tvalid && !stat.out_hold) begin
                    cmd.step_en = 1'b1;
                    if (stat.meas_close) begin
                        state_next = ST_MUL;
                    end else begin
                        cmd.step_out = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                cmd.prod_load = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.res_from_div = 1'b1;
                state_next       = ST_READY;
            end
            default: begin
                state_next = ST_READY;
            end
        endcase
    end

endmodule

// ===== sv/csrgb_dp.sv =====
// ----------------------------------------------------------------------------
// csrgb_dp
// Datapath: window and edge counters, channel gains, scale multiply,
// restoring divider and the output register.
// ----------------------------------------------------------------------------
module csrgb_dp #(
    parameter int COUNT_WIDTH = csrgb_pkg::COUNT_WIDTH_DEF,
    parameter int FULL_SCALE  = csrgb_pkg::FULL_SCALE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [csrgb_pkg::WIN_W-1:0]   cfg_wr_data,
    input  logic [csrgb_pkg::IN_W-1:0]    s_tdata,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [csrgb_pkg::OUT_W-1:0]   m_tdata,
    input  csrgb_pkg::cmd_t               cmd,
    output csrgb_pkg::stat_t              stat
);
    import csrgb_pkg::*;

    localparam int FS_W  = $clog2(FULL_SCALE + 1);
    localparam int DIV_W = COUNT_WIDTH + ((FS_W > DIV_STEPS) ? FS_W : DIV_STEPS);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [WIN_W-1:0]       window_reg;
    mode_t                  mode_reg, mode_next;
    logic [CHAN_W-1:0]      chan_reg, chan_next;
    logic [WIN_W-1:0]       win_cnt_reg, win_cnt_next;
    logic [COUNT_WIDTH-1:0] edge_cnt_reg, edge_cnt_next;
    logic [COUNT_WIDTH-1:0] gain_reg [3];

    logic [COUNT_WIDTH-1:0] hold_cnt_reg;
    logic [CHAN_W-1:0]      hold_idx_reg;
    logic [DIV_W-1:0]       rem_reg;
    logic [DIV_W-1:0]       dvs_reg;
    logic [DIV_STEPS-1:0]   quo_reg;
    logic [DCNT_W-1:0]      dcnt_reg;

    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;

    logic [ACT_W-1:0]       act;
    logic                   pulse;
    logic [WIN_W-1:0]       limit;
    logic [WIN_W-1:0]       win_inc;
    logic [COUNT_WIDTH-1:0] edge_inc;
    logic                   close;
    logic                   cal_done;
    logic                   rem_ge;
    logic                   gz;
    logic [VALUE_W-1:0]     value;

    assign act     = s_tdata[ACT_W-1:0];
    assign pulse   = s_tdata[ACT_W];
    assign limit   = (window_reg == '0) ? WIN_W'(1) : window_reg;
    assign win_inc = win_cnt_reg + WIN_W'(1);
    assign edge_inc = (pulse && edge_cnt_reg != CNT_MAX) ?
                      edge_cnt_reg + COUNT_WIDTH'(1) : edge_cnt_reg;
    assign close    = (mode_reg != MODE_IDLE) && (win_inc >= limit);
    assign cal_done = close && (mode_reg == MODE_CAL) && (chan_reg == CHAN_LAST);

    assign stat.meas_close = close && (mode_reg == MODE_MEAS);
    assign stat.div_last   = (dcnt_reg == '0);
    assign stat.out_hold   = out_valid_reg && !m_tready;

    always_comb begin
        mode_next     = mode_reg;
        chan_next     = chan_reg;
        win_cnt_next  = win_cnt_reg;
        edge_cnt_next = edge_cnt_reg;
        if (mode_reg == MODE_IDLE) begin
            if (act inside {ACT_CAL, ACT_MEAS}) begin
                mode_next     = (act == ACT_CAL) ? MODE_CAL : MODE_MEAS;
                chan_next     = '0;
                win_cnt_next  = '0;
                edge_cnt_next = '0;
            end
        end else begin
            win_cnt_next  = win_inc;
            edge_cnt_next = edge_inc;
            if (close) begin
                win_cnt_next  = '0;
                edge_cnt_next = '0;
                if (chan_reg == CHAN_LAST) begin
                    mode_next = MODE_IDLE;
                    chan_next = '0;
                end else begin
                    chan_next = chan_reg + CHAN_W'(1);
                end
            end
        end
    end

    // control state and gains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= WINDOW_RESET;
            mode_reg     <= MODE_IDLE;
            chan_reg     <= '0;
            win_cnt_reg  <= '0;
            edge_cnt_reg <= '0;
            gain_reg[0]  <= '0;
            gain_reg[1]  <= '0;
            gain_reg[2]  <= '0;
            dcnt_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
            if (cmd.step_en) begin
                mode_reg     <= mode_next;
                chan_reg     <= chan_next;
                win_cnt_reg  <= win_cnt_next;
                edge_cnt_reg <= edge_cnt_next;
                if (close && mode_reg == MODE_CAL) begin
                    gain_reg[chan_reg] <= edge_inc;
                end
            end
            if (cmd.prod_load) begin
                dcnt_reg <= DCNT_W'(DIV_STEPS - 1);
            end else if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            end
        end
    end

    assign rem_ge = (rem_reg >= dvs_reg);

    // closing count, scale product and divider
    always_ff @(posedge aclk) begin
        if (cmd.step_en) begin
            hold_cnt_reg <= edge_inc;
            hold_idx_reg <= chan_reg;
        end
        if (cmd.prod_load) begin
            rem_reg <= DIV_W'(hold_cnt_reg) * DIV_W'(FULL_SCALE);
            dvs_reg <= DIV_W'(gain_reg[hold_idx_reg]) << VALUE_W;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            if (rem_ge) begin
                rem_reg <= rem_reg - dvs_reg;
            end
            quo_reg <= {quo_reg[DIV_STEPS-2:0], rem_ge};
            dvs_reg <= dvs_reg >> 1;
        end
    end

    // top quotient bit set means the scaled value is past full range
    assign gz    = (gain_reg[hold_idx_reg] == '0);
    assign value = (gz || quo_reg[DIV_STEPS-1]) ? {VALUE_W{1'b1}} : quo_reg[VALUE_W-1:0];

    always_comb begin
        if (cmd.res_from_div) begin
            out_data_next = {1'b0, gz, value, hold_idx_reg, 1'b1, 1'b1 ^ (mode_reg == MODE_IDLE),
                             sel_of(mode_reg, chan_reg)};
        end else begin
            out_data_next = {cal_done, 1'b0, {VALUE_W{1'b0}}, {CHAN_W{1'b0}}, 1'b0,
                             mode_next != MODE_IDLE, sel_of(mode_next, chan_next)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.step_out || cmd.res_from_div) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_out || cmd.res_from_div) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sv/color_sensor_pulse_to_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// color_sensor_pulse_to_rgb_unit
// Colour sensor gate counter with white balance, one result per request.
//
//   port group | dir | contents
//   s_*        | in  | tick / start request: action, pulse_edge
//   m_*        | out | status and scaled colour value
//   cfg_*      | in  | gate window length write
//
// One request a cycle while a pass counts and no result waits on m_tready. A
// request that closes a measurement window runs through the accepting cycle,
// the scale multiply, 9 divider steps and the result load on the shared
// restoring divider.
// s_tready is low from the scale multiply through the result load and while a result waits on m_tready.
// aresetn is synchronous; after reset the block is idle with zero gains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module color_sensor_pulse_to_rgb_unit #(
    parameter int COUNT_WIDTH = csrgb_pkg::COUNT_WIDTH_DEF,
    parameter int FULL_SCALE  = csrgb_pkg::FULL_SCALE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [csrgb_pkg::WIN_W-1:0]   cfg_wr_data,   // window_ticks
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] action, [2] pulse_edge, [7:3] zero
    input  logic [csrgb_pkg::IN_W-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] filter_select, [2] busy_res, [3] result_valid, [5:4] channel,
    // [13:6] color_value, [14] gain_zero, [15] calibration_done
    output logic [csrgb_pkg::OUT_W-1:0]   m_tdata
);
    import csrgb_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    csrgb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csrgb_dp #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .FULL_SCALE  (FULL_SCALE)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

    `CHK_ALWAYS(a_no_take_when_full, s_tready |-> (!m_tvalid || m_tready), "request taken over a held result")
    `CHK_PROP(a_result_source, $rose(m_tvalid) |-> $past(cmd.step_out || cmd.res_from_div), "result with no source")
    `CHK_PROP(a_cal_no_value, (m_tvalid && m_tdata[15]) |-> !m_tdata[3], "calibration end carries a value")
    `CHK_PROP(a_zero_gain_full, (m_tvalid && m_tdata[14]) |-> (m_tdata[13:6] == 8'hFF), "zero gain value not full")

endmodule
